// ----- hdl/thinc_face_fraction_macros.svh -----
// Assertion macros shared by the thinc_face_fraction RTL
`ifndef THINC_FACE_FRACTION_MACROS_SVH
`define THINC_FACE_FRACTION_MACROS_SVH

// same-cycle implication, checked out of reset
`define TFF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tff_pkg.sv -----
// Shared constants, tables and types for the THINC face fraction block
package tff_pkg;

    localparam int GaussPoints = 2;
    localparam int GaussSel    = GaussPoints - 1;

    localparam int HornerSteps = 7;
    localparam int DivSteps    = 31;
    // lane: products, sum, scale, log2 scale, ln2 scale, Horner, shift, mults, num/den, divide
    localparam int LaneStages  = 5 + 3 * HornerSteps + 3 + DivSteps;
    // lane, weight products, output register
    localparam int TotalStages = LaneStages + 2;

    localparam logic [30:0] OneQ30   = 31'd1073741824;
    localparam logic signed [30:0] HalfQ30 = 31'sd536870912;
    localparam logic [30:0] Log2eQ30 = 31'd1549082005;
    localparam logic [29:0] Ln2Q30   = 30'd744261118;
    localparam logic [16:0] FullQ15  = 17'd32768;

    localparam logic [15:0] SharpnessReset = 16'd2560;

    typedef logic signed [30:0] t_coord;
    typedef logic [DivSteps-1:0] t_point;

    localparam t_coord GaussPos [4][4] = '{
        '{31'sd0, 31'sd0, 31'sd0, 31'sd0},
        '{-31'sd309962566, 31'sd309962566, 31'sd0, 31'sd0},
        '{-31'sd415858420, 31'sd0, 31'sd415858420, 31'sd0},
        '{-31'sd462319037, -31'sd182525933, 31'sd182525933, 31'sd462319037}
    };

    localparam logic [30:0] GaussWt [4][4] = '{
        '{31'd1073741824, 31'd0, 31'd0, 31'd0},
        '{31'd536870912, 31'd536870912, 31'd0, 31'd0},
        '{31'd298261618, 31'd477218588, 31'd298261618, 31'd0},
        '{31'd186753148, 31'd350117764, 31'd350117764, 31'd186753148}
    };

endpackage

// ----- hdl/thinc_face_fraction.sv -----
// Top level of the THINC face fraction pipeline
// THINC face volume fraction. One face item is accepted per clock unless
// the result side stalls; the depth is TotalStages in tff_pkg. Each Gauss point
// has its own lane, whose depth is set by the 21-stage exp series (seven
// terms, three stages each) and the 31-stage restoring divider. A stall on the
// result side freezes the whole pipeline; bubbles are not squeezed out. The
// sharpness register sits at byte address 0 and must only be written while
// no item is in flight. Faces whose upwind fraction is empty, full or above
// full are passed through as empty or full and flagged on o_passed_through.
module thinc_face_fraction (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_face_is_z,
    input  logic               i_velocity_negative,
    input  logic [15:0]        i_lower_fraction,
    input  logic signed [15:0] i_lower_normal_x,
    input  logic signed [15:0] i_lower_normal_z,
    input  logic [15:0]        i_upper_fraction,
    input  logic signed [15:0] i_upper_normal_x,
    input  logic signed [15:0] i_upper_normal_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_face_fraction,
    output logic               o_passed_through,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tff_pkg::*;

    `include "thinc_face_fraction_macros.svh"

    localparam logic RegIdxSharpness = 1'b0;

    logic [15:0] r_sharp;
    logic        en;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegIdxSharpness) ? {16'd0, r_sharp} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sharp <= SharpnessReset;
        end else if (psel && penable && pwrite && (paddr[2] == RegIdxSharpness)) begin
            r_sharp <= pwdata[15:0];
        end
    end

    // upwind select
    logic [15:0]        c_v;
    logic signed [15:0] c_nx, c_nz;
    t_coord             c_edge;

    assign c_v    = i_velocity_negative ? i_upper_fraction : i_lower_fraction;
    assign c_nx   = i_velocity_negative ? i_upper_normal_x : i_lower_normal_x;
    assign c_nz   = i_velocity_negative ? i_upper_normal_z : i_lower_normal_z;
    assign c_edge = i_velocity_negative ? -HalfQ30 : HalfQ30;

    assign o_stall = o_valid && i_stall;
    assign en      = !o_stall;

    t_point c_pv [GaussPoints];

    for (genvar k = 0; k < GaussPoints; k++) begin : g_lane
        t_coord c_px, c_pz;

        assign c_px = i_face_is_z ? GaussPos[GaussSel][k] : c_edge;
        assign c_pz = i_face_is_z ? c_edge : GaussPos[GaussSel][k];

        tff_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_v     (c_v),
            .i_nx    (c_nx),
            .i_nz    (c_nz),
            .i_px    (c_px),
            .i_pz    (c_pz),
            .i_sharp (r_sharp),
            .o_pv    (c_pv[k])
        );
    end

    // valid and pass-through flags run beside the lanes
    logic [TotalStages-1:0] r_vld;
    logic [TotalStages-1:0] r_pt;
    logic [TotalStages-1:0] r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TotalStages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt   <= {r_pt[TotalStages-2:0], (c_v == '0) || c_v[15]};
            r_full <= {r_full[TotalStages-2:0], c_v[15]};
        end
    end

    // weighted sum of the point values, round half up to Q1.15
    logic [61:0] r_wprod [GaussPoints];
    logic [63:0] c_acc;
    logic [63:0] c_sum;
    logic [18:0] c_res;
    logic [15:0] c_frac;
    logic [15:0] r_frac;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < GaussPoints; k++) begin
                r_wprod[k] <= 62'(GaussWt[GaussSel][k]) * 62'(c_pv[k]);
            end
        end
    end

    always_comb begin
        c_acc = '0;
        for (int k = 0; k < GaussPoints; k++) begin
            c_acc = c_acc + 64'(r_wprod[k]);
        end
    end

    assign c_sum  = c_acc + (64'd1 << 44);
    assign c_res  = c_sum[63:45];
    assign c_frac = (c_res > 19'(FullQ15)) ? 16'(FullQ15) : c_res[15:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_pt[TotalStages-2]) begin
                r_frac <= r_full[TotalStages-2] ? 16'(FullQ15) : '0;
            end else begin
                r_frac <= c_frac;
            end
        end
    end

    assign o_valid          = r_vld[TotalStages-1];
    assign o_face_fraction  = r_frac;
    assign o_passed_through = r_pt[TotalStages-1];

    `TFF_ASSERT_SAME(a_stall_needs_item, o_stall, o_valid, "stall with no item waiting")
    `TFF_ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, r_vld[0], "accepted item lost")
    `TFF_ASSERT_NEXT(a_stall_freezes, o_stall, $stable(r_vld), "pipeline moved while stalled")
    `TFF_ASSERT_SAME(a_result_range, o_valid, 17'(o_face_fraction) <= FullQ15, "fraction above full")
    `TFF_ASSERT_SAME(a_pass_value, o_valid && o_passed_through,
        (o_face_fraction == '0) || (17'(o_face_fraction) == FullQ15), "bad copied fraction")

endmodule

// ----- hdl/tff_lane.sv -----
// One Gauss point lane: profile exponent, exp series, and restoring divider
module tff_lane (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [15:0]          i_v,
    input  logic signed [15:0]   i_nx,
    input  logic signed [15:0]   i_nz,
    input  tff_pkg::t_coord      i_px,
    input  tff_pkg::t_coord      i_pz,
    input  logic [15:0]          i_sharp,
    output tff_pkg::t_point      o_pv
);
    import tff_pkg::*;

    typedef struct packed {
        logic [29:0] g;
        logic        zero;
        logic [4:0]  sh;
        logic [15:0] v;
        logic        neg;
    } t_ctx;

    // stage 1: coordinate products
    logic signed [46:0] r1_prodx, r1_prodz;
    logic [15:0]        r1_v;
    // stage 2: p and its magnitude
    logic signed [47:0] c_p;
    logic [45:0]        r2_mag;
    logic               r2_neg;
    logic [15:0]        r2_v;
    // stage 3: |p| * beta
    logic [61:0]        r3_ps;
    logic               r3_neg;
    logic [15:0]        r3_v;
    // stage 4: U * log2(e)
    logic [56:0]        r4_w;
    logic               r4_neg;
    logic [15:0]        r4_v;
    // stage 5: split exponent, fraction times ln2
    logic [26:0]        c_w;
    logic [10:0]        c_n;
    logic [45:0]        c_gprod;
    t_ctx               r5_ctx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prodx <= 47'(i_nx) * 47'(i_px);
            r1_prodz <= 47'(i_nz) * 47'(i_pz);
            r1_v     <= i_v;
        end
    end

    assign c_p = 48'(r1_prodx) + 48'(r1_prodz);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mag <= c_p[47] ? 46'(-c_p) : 46'(c_p);
            r2_neg <= c_p[47];
            r2_v   <= r1_v;
            // a = 0 when beta is zero, which takes the non-negative branch
            r3_ps  <= 62'(r2_mag) * 62'(i_sharp);
            r3_neg <= r2_neg && (i_sharp != '0);
            r3_v   <= r2_v;
            r4_w   <= 57'(r3_ps[61:36]) * 57'(Log2eQ30);
            r4_neg <= r3_neg;
            r4_v   <= r3_v;
        end
    end

    assign c_w     = r4_w[56:30];
    assign c_n     = c_w[26:16];
    assign c_gprod = 46'(c_w[15:0]) * 46'(Ln2Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ctx.g    <= c_gprod[45:16];
            r5_ctx.zero <= (c_n >= 11'd31);
            r5_ctx.sh   <= c_n[4:0];
            r5_ctx.v    <= r4_v;
            r5_ctx.neg  <= r4_neg;
        end
    end

    // Horner series for 2^-f, three stages per term: g*r, reciprocal, correct
    logic [29:0] r_ax   [HornerSteps];
    t_ctx        r_actx [HornerSteps];
    logic [62:0] r_bt   [HornerSteps];
    logic [29:0] r_bx   [HornerSteps];
    t_ctx        r_bctx [HornerSteps];
    logic [30:0] r_hr   [HornerSteps];
    t_ctx        r_hctx [HornerSteps];

    for (genvar j = 0; j < HornerSteps; j++) begin : g_horner
        localparam int K = HornerSteps - j;
        localparam logic [32:0] Recip = 33'((64'd1 << 32) / K);
        localparam logic [32:0] KW    = 33'(K);

        t_ctx        c_in;
        logic [30:0] c_rprev;
        logic [60:0] c_m;
        logic [29:0] c_q0;
        logic [32:0] c_rem;
        logic [29:0] c_q;

        if (j == 0) begin : g_first
            assign c_in    = r5_ctx;
            assign c_rprev = OneQ30;
        end else begin : g_next
            assign c_in    = r_hctx[j-1];
            assign c_rprev = r_hr[j-1];
        end

        assign c_m   = 61'(c_in.g) * 61'(c_rprev);
        assign c_q0  = r_bt[j][61:32];
        // reciprocal estimate is low by at most one
        assign c_rem = 33'(r_bx[j]) - 33'(c_q0) * KW;
        assign c_q   = c_q0 + 30'(c_rem >= KW);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ax[j]   <= c_m[59:30];
                r_actx[j] <= c_in;
                r_bt[j]   <= 63'(r_ax[j]) * 63'(Recip);
                r_bx[j]   <= r_ax[j];
                r_bctx[j] <= r_actx[j];
                r_hr[j]   <= OneQ30 - 31'(c_q);
                r_hctx[j] <= r_bctx[j];
            end
        end
    end

    // exp, then the products that build numerator and denominator
    logic [30:0] r_e;
    logic [15:0] r_ev;
    logic        r_eneg;
    logic [46:0] r_mve, r_mce;
    logic [15:0] r_mv, r_mc;
    logic        r_mneg;
    logic [46:0] r_d0num, r_d0den;
    logic [46:0] c_vhi, c_chi;

    assign c_vhi = 47'(r_mv) << 30;
    assign c_chi = 47'(r_mc) << 30;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e     <= r_hctx[HornerSteps-1].zero ? '0 :
                       (r_hr[HornerSteps-1] >> r_hctx[HornerSteps-1].sh);
            r_ev    <= r_hctx[HornerSteps-1].v;
            r_eneg  <= r_hctx[HornerSteps-1].neg;
            r_mve   <= 47'(r_ev) * 47'(r_e);
            r_mce   <= 47'(16'(FullQ15 - 17'(r_ev))) * 47'(r_e);
            r_mv    <= r_ev;
            r_mc    <= 16'(FullQ15 - 17'(r_ev));
            r_mneg  <= r_eneg;
            r_d0num <= r_mneg ? r_mve : c_vhi;
            r_d0den <= r_mneg ? (r_mve + c_chi) : (c_vhi + r_mce);
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    logic [46:0] r_drem [DivSteps];
    logic [46:0] r_dden [DivSteps];
    t_point      r_dq   [DivSteps];

    for (genvar i = 0; i < DivSteps; i++) begin : g_div
        logic [47:0] c_trial;
        logic [46:0] c_den;
        t_point      c_qprev;
        logic        c_ge;

        if (i == 0) begin : g_first
            assign c_trial = 48'(r_d0num);
            assign c_den   = r_d0den;
            assign c_qprev = '0;
        end else begin : g_next
            assign c_trial = {r_drem[i-1], 1'b0};
            assign c_den   = r_dden[i-1];
            assign c_qprev = r_dq[i-1];
        end

        assign c_ge = c_trial >= 48'(c_den);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[i] <= c_ge ? 47'(c_trial - 48'(c_den)) : 47'(c_trial);
                r_dden[i] <= c_den;
                r_dq[i]   <= {c_qprev[DivSteps-2:0], c_ge};
            end
        end
    end

    assign o_pv = r_dq[DivSteps-1];

endmodule

// ----- bench/thinc_face_fraction_test.sv -----
// Self-checking testbench for the THINC face fraction pipeline
module thinc_face_fraction_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit               face_is_z;
        bit               velocity_negative;
        bit [15:0]        lower_fraction;
        bit signed [15:0] lower_normal_x;
        bit signed [15:0] lower_normal_z;
        bit [15:0]        upper_fraction;
        bit signed [15:0] upper_normal_x;
        bit signed [15:0] upper_normal_z;
    } face_t;

    typedef struct {
        bit [15:0] face_fraction;
        bit        passed_through;
    } face_frac_t;

    // tanh profile predictor and in-order store of expected face fractions
    class face_frac_board;
        localparam longint unsigned ONE_Q30   = 64'd1073741824;
        localparam longint          HALF_Q30  = 64'sd536870912;
        localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
        localparam longint unsigned LN2_Q30   = 64'd744261118;
        localparam longint unsigned FULL_Q15  = 64'd32768;
        localparam longint          GAUSS_POS = 64'sd309962566;
        localparam longint unsigned GAUSS_WT  = 64'd536870912;

        bit [15:0]  sharpness = 16'd2560;
        face_frac_t expected_q[$];
        int         errors = 0;

        task report(string what, longint unsigned got, longint unsigned want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        function longint unsigned exp_neg(longint unsigned u);
            longint unsigned w, n, f, g, r;
            w = (u * LOG2E_Q30) >> 30;
            n = w >> 16;
            f = w & 64'hFFFF;
            g = (f * LN2_Q30) >> 16;
            r = ONE_Q30;
            if (n >= 31) return 0;
            for (int k = 7; k >= 1; k--)
                r = ONE_Q30 - ((g * r) >> 30) / longint'(k);
            return r >> n;
        endfunction

        function longint unsigned div_q30(longint unsigned num, longint unsigned den);
            longint unsigned q1, r1;
            q1 = (num << 15) / den;
            r1 = (num << 15) % den;
            return (q1 << 15) + ((r1 << 15) / den);
        endfunction

        function longint unsigned point_frac(longint unsigned v, longint nx, longint nz,
                                             longint px, longint pz);
            longint          p, a;
            longint unsigned mag, e, c;
            p = nx * px + nz * pz;
            a = p * longint'(sharpness) * 2;
            mag = a < 0 ? longint'(-a) : a;
            e = exp_neg(mag >> 37);
            c = FULL_Q15 - v;
            if (a >= 0)
                return div_q30(v << 30, (v << 30) + c * e);
            return div_q30(v * e, v * e + (c << 30));
        endfunction

        function void note_face(face_t f);
            longint unsigned v, acc, pv;
            longint          nx, nz, face_pos, gp;
            face_frac_t      r;
            v        = f.velocity_negative ? f.upper_fraction : f.lower_fraction;
            nx       = f.velocity_negative ? f.upper_normal_x : f.lower_normal_x;
            nz       = f.velocity_negative ? f.upper_normal_z : f.lower_normal_z;
            face_pos = f.velocity_negative ? -HALF_Q30 : HALF_Q30;
            if (v == 0 || v >= FULL_Q15) begin
                r.face_fraction  = v == 0 ? 16'd0 : 16'd32768;
                r.passed_through = 1'b1;
            end else begin
                acc = 0;
                for (int k = 0; k < 2; k++) begin
                    gp = k == 0 ? -GAUSS_POS : GAUSS_POS;
                    pv = f.face_is_z ? point_frac(v, nx, nz, gp, face_pos)
                                     : point_frac(v, nx, nz, face_pos, gp);
                    acc += GAUSS_WT * pv;
                end
                acc = (acc + (64'd1 << 44)) >> 45;
                if (acc > FULL_Q15) acc = FULL_Q15;
                r.face_fraction  = acc[15:0];
                r.passed_through = 1'b0;
            end
            expected_q.push_back(r);
        endfunction

        task check_result(bit [15:0] frac, bit passed);
            face_frac_t w;
            if (expected_q.size() == 0) begin
                report("unexpected item", frac, 0);
                return;
            end
            w = expected_q.pop_front();
            if (frac !== w.face_fraction) report("face_fraction", frac, w.face_fraction);
            if (passed !== w.passed_through) report("passed_through", passed, w.passed_through);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_face_is_z = 1'b0;
    logic               i_velocity_negative = 1'b0;
    logic [15:0]        i_lower_fraction = '0;
    logic signed [15:0] i_lower_normal_x = '0;
    logic signed [15:0] i_lower_normal_z = '0;
    logic [15:0]        i_upper_fraction = '0;
    logic signed [15:0] i_upper_normal_x = '0;
    logic signed [15:0] i_upper_normal_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic [15:0]        o_face_fraction;
    logic               o_passed_through;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    localparam logic [2:0] ADDR_SHARPNESS = 3'd0;
    localparam int         DRAIN_CYCLES   = 80;
    localparam int         WATCHDOG_LIMIT = 3000;

    face_frac_board board = new();
    bit             no_gaps;        // sender burst mode
    bit             no_stalls;      // receiver burst mode
    int             stall_left = 0;
    int             idle_cycles = 0;

    thinc_face_fraction dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                board.note_face('{i_face_is_z, i_velocity_negative, i_lower_fraction,
                                  i_lower_normal_x, i_lower_normal_z, i_upper_fraction,
                                  i_upper_normal_x, i_upper_normal_z});
            if (o_valid && !i_stall)
                board.check_result(o_face_fraction, o_passed_through);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver: random stall before each item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall = stall_left > 0;
        end else begin
            if (o_valid && !i_stall)
                stall_left = no_stalls ? 0 : $urandom_range(0, 9);
            i_stall = stall_left > 0;
        end
    end

    task write_sharpness(bit [15:0] value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; paddr = ADDR_SHARPNESS; pwdata = {16'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        board.sharpness = value;
    endtask

    task send_face(face_t f);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_face_is_z = f.face_is_z;
        i_velocity_negative = f.velocity_negative;
        i_lower_fraction = f.lower_fraction;
        i_lower_normal_x = f.lower_normal_x;
        i_lower_normal_z = f.lower_normal_z;
        i_upper_fraction = f.upper_fraction;
        i_upper_normal_x = f.upper_normal_x;
        i_upper_normal_z = f.upper_normal_z;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function bit [15:0] rand_fraction();
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'($urandom_range(32769, 65535));
            3:       return 16'($urandom_range(1, 40));
            4:       return 16'($urandom_range(32720, 32767));
            default: return 16'($urandom_range(1, 32767));
        endcase
    endfunction

    function face_t rand_face();
        face_t f;
        f.face_is_z = 1'($urandom_range(0, 1));
        f.velocity_negative = 1'($urandom_range(0, 1));
        f.lower_fraction = rand_fraction();
        f.upper_fraction = rand_fraction();
        f.lower_normal_x = 16'($urandom);
        f.lower_normal_z = 16'($urandom);
        f.upper_normal_x = 16'($urandom);
        f.upper_normal_z = 16'($urandom);
        return f;
    endfunction

    task drain();
        i_valid = 1'b0;
        wait (board.expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task run_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                no_gaps = $urandom_range(0, 3) == 0;
                no_stalls = $urandom_range(0, 3) == 0;
            end
            send_face(rand_face());
        end
        drain();
    endtask

    bit [15:0] sharp_list[5] = '{16'd65535, 16'd1, 16'd0, 16'd256, 16'd2560};

    initial begin
        face_t f;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: pass-through and edge cases at reset sharpness
        no_gaps = 1'b0; no_stalls = 1'b0;
        for (int i = 0; i < 20; i++) begin
            f = '{i[0], i[1], 16'd16384, 16'sd23170, 16'sd23170,
                  16'd16384, -16'sd23170, 16'sd23170};
            case (i / 4)
                0: begin f.lower_fraction = 16'd0; f.upper_fraction = 16'd0; end
                1: begin f.lower_fraction = 16'd32768; f.upper_fraction = 16'd32768; end
                2: begin f.lower_fraction = 16'hFFFF; f.upper_fraction = 16'd32769; end
                3: begin
                    f.lower_fraction = 16'd1; f.upper_fraction = 16'd32767;
                    f.lower_normal_x = 16'sh7FFF; f.upper_normal_z = 16'sh8000;
                end
                default: begin
                    f.lower_normal_x = 16'sh8000; f.lower_normal_z = 16'sh8000;
                    f.upper_normal_x = 16'sh7FFF; f.upper_normal_z = 16'sh7FFF;
                end
            endcase
            send_face(f);
        end
        drain();
        run_random(300);

        foreach (sharp_list[s]) begin
            write_sharpness(s == 3 ? 16'($urandom_range(1, 65535)) : sharp_list[s]);
            run_random(300);
        end

        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
